@@ sv/chfxy_pkg.sv @@
// Package: payload types and fixed constants for the compass heading block.
package chfxy_pkg;

    typedef struct packed {
        logic signed [15:0] field_x;
        logic signed [15:0] field_y;
    } in_req_t;

    typedef struct packed {
        logic [15:0] heading_centideg;
        logic        zero_vector;
    } out_req_t;

    localparam logic [35:0] C32_A1      = 36'd4294391770;
    localparam logic [35:0] C32_A3      = 36'd1418625550;
    localparam logic [35:0] C32_A5      = 36'd773699704;
    localparam logic [35:0] C32_A7      = 36'd365643451;
    localparam logic [35:0] C32_A9      = 36'd89486073;
    localparam logic [35:0] C32_HALF_PI = 36'd6746518737;
    localparam logic [35:0] C32_PI      = 36'd13493037474;

    localparam int CENTI_HALF_TURN = 18000;
    localparam int CENTI_FULL_TURN = 36000;

    localparam logic REG_X_OFFSET = 1'b0;
    localparam logic REG_Y_OFFSET = 1'b1;

endpackage

@@ sv/compass_heading_from_xy.sv @@
// Top level: pipelined compass heading from one hard-iron corrected X/Y sample.
//
//  channel  | valid     | stall     | payload
//  ---------+-----------+-----------+------------------------------
//  request  | in_valid  | in_stall  | in_data  (chfxy_pkg::in_req_t)
//  result   | out_valid | out_stall | out_data (chfxy_pkg::out_req_t)
//  config   | cfg_we    | -         | cfg_index, cfg_data
//
// One request per cycle while out_stall is not holding the pipeline; input stage,
// divider with one stage per numerator bit, eight polynomial/angle/scale stages,
// output register. Whole pipeline holds when out_valid is high and out_stall is high;
// in_stall follows that. Reset clears valid bits and offsets to zero.
module compass_heading_from_xy #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  chfxy_pkg::in_req_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output chfxy_pkg::out_req_t out_data,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data
);
    localparam int F    = FRACTION_BITS;
    localparam int NUMW = F + 16;
    localparam int CW   = F + 3;
    localparam int NP   = 8;

    function automatic logic [CW-1:0] fx(input logic [35:0] c);
        logic [36:0] t;
        begin
            t = {1'b0, c} + (37'd1 << (31 - F));
            fx = CW'(t >> (32 - F));
        end
    endfunction

    localparam logic [CW-1:0] A1  = fx(chfxy_pkg::C32_A1);
    localparam logic [CW-1:0] A3  = fx(chfxy_pkg::C32_A3);
    localparam logic [CW-1:0] A5  = fx(chfxy_pkg::C32_A5);
    localparam logic [CW-1:0] A7  = fx(chfxy_pkg::C32_A7);
    localparam logic [CW-1:0] A9  = fx(chfxy_pkg::C32_A9);
    localparam logic [CW-1:0] HPI = fx(chfxy_pkg::C32_HALF_PI);
    localparam logic [CW-1:0] PI  = fx(chfxy_pkg::C32_PI);
    localparam logic [CW:0]   PI2 = {PI, 1'b0};
    // centi = (theta*36000 + PI) / (2*PI) as (theta*K + half) >> SH with K = ceil;
    // exact while theta*2*PI < 2^SH
    localparam int SH = 2 * F + 6;
    localparam int KW = F + 20;
    localparam int PW = CW + 1 + KW;
    localparam logic [KW-1:0] K =
        KW'(((128'd36000 << SH) + 128'(PI2) - 128'd1) / 128'(PI2));

    // tag: zero, steep, sx, sy
    localparam int TAGW = 4;

    logic signed [15:0] xo_reg, yo_reg;
    logic adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xo_reg <= '0;
            yo_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == chfxy_pkg::REG_X_OFFSET) xo_reg <= cfg_data;
            else yo_reg <= cfg_data;
        end
    end

    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    // stage 0: correction, magnitudes
    logic            s0_vld_reg;
    logic [NUMW-1:0] s0_num_reg;
    logic [15:0]     s0_den_reg;
    logic [TAGW-1:0] s0_tag_reg;
    logic signed [16:0] cx, cy;
    logic [16:0] ax, ay;
    logic        stp;

    always_comb
    begin
        cx  = 17'(in_data.field_x) - 17'(xo_reg);
        cy  = 17'(in_data.field_y) - 17'(yo_reg);
        ax  = cx[16] ? 17'(-cx) : cx;
        ay  = cy[16] ? 17'(-cy) : cy;
        stp = ay > ax;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s0_vld_reg <= 1'b0;
        else if (adv) s0_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_num_reg <= {(stp ? ax[15:0] : ay[15:0]), {F{1'b0}}};
            s0_den_reg <= (cx == 0 && cy == 0) ? 16'd1 : (stp ? ay[15:0] : ax[15:0]);
            s0_tag_reg <= {(cx == 0 && cy == 0), stp, cx[16], cy[16]};
        end
    end

    logic            d_vld;
    logic [NUMW-1:0] d_quo;
    logic [TAGW-1:0] d_tag;

    chfxy_div #(.NUM_W(NUMW), .DEN_W(16), .TAG_W(TAGW)) u_div (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_vld(s0_vld_reg), .in_num(s0_num_reg), .in_den(s0_den_reg), .in_tag(s0_tag_reg),
        .out_vld(d_vld), .out_quo(d_quo), .out_tag(d_tag)
    );

    // polynomial pipeline: p0 z2, p1..p4 Horner, p5 z*t, p6 angle, p7 scale
    logic            pv_reg [NP];
    logic [TAGW-1:0] pg_reg [NP];
    logic [F:0]      z_reg  [NP];
    logic [CW-1:0]   z2_reg [NP];
    logic [CW-1:0]   t_reg  [NP];
    logic [CW:0]     th_reg;
    logic [PW-1:0]   ce_reg;

    function automatic logic [CW-1:0] mr(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic [2*CW-1:0] p;
        begin
            p  = (2*CW)'(a) * (2*CW)'(b) + ((2*CW)'(1) << (F - 1));
            mr = CW'(p >> F);
        end
    endfunction

    logic [CW-1:0] zq, pw;
    logic signed [CW+1:0] th0, th1;
    logic [15:0] cn;
    logic [15:0] cen;

    always_comb
    begin
        zq  = CW'(d_quo[F:0]);
        pw  = mr(CW'(z_reg[4]), t_reg[4]);
        th0 = pg_reg[5][2] ? $signed({2'b0, HPI}) - $signed({2'b0, t_reg[5]})
                           : $signed({2'b0, t_reg[5]});
        if (pg_reg[5][1]) th0 = $signed({2'b0, PI}) - th0;
        th1 = pg_reg[5][0] ? -th0 : th0;
        if (th1 < 0) th1 = th1 + $signed({1'b0, PI2});
        cn  = ce_reg[SH+15:SH];
        cen = (cn >= 16'(chfxy_pkg::CENTI_FULL_TURN))
            ? 16'(cn - 16'(chfxy_pkg::CENTI_FULL_TURN)) : cn;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NP; i++) pv_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            pv_reg[0] <= d_vld;
            for (int i = 1; i < NP; i++) pv_reg[i] <= pv_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pg_reg[0] <= d_tag;
            z_reg[0]  <= d_quo[F:0];
            z2_reg[0] <= mr(zq, zq);
            t_reg[0]  <= A9;
            for (int i = 1; i < NP; i++)
            begin
                pg_reg[i] <= pg_reg[i-1];
                z_reg[i]  <= z_reg[i-1];
                z2_reg[i] <= z2_reg[i-1];
            end
            t_reg[1] <= A7 - mr(z2_reg[0], t_reg[0]);
            t_reg[2] <= A5 - mr(z2_reg[1], t_reg[1]);
            t_reg[3] <= A3 - mr(z2_reg[2], t_reg[2]);
            t_reg[4] <= A1 - mr(z2_reg[3], t_reg[3]);
            t_reg[5] <= pw;
            t_reg[6] <= t_reg[5];
            t_reg[7] <= t_reg[6];
            th_reg   <= CW'(th1) == CW'(0) && th1[CW] == 1'b0 ? '0 : (CW+1)'(th1);
            ce_reg   <= PW'(th_reg) * PW'(K) + (PW'(1) << (SH - 1));
        end
    end

    // pv_reg[6]: th_reg valid, pv_reg[7]: ce_reg valid
    logic           o_vld_reg;
    chfxy_pkg::out_req_t o_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) o_vld_reg <= 1'b0;
        else if (adv) o_vld_reg <= pv_reg[7];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_reg.zero_vector      <= pg_reg[7][3];
            o_reg.heading_centideg <= pg_reg[7][3] ? 16'd0 : cen;
        end
    end

    assign out_valid = o_vld_reg;
    assign out_data  = o_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.heading_centideg < 16'd36000)
        else $error("heading out of range");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.zero_vector |-> out_data.heading_centideg == 16'd0)
        else $error("zero vector with nonzero heading");
endmodule

@@ sv/chfxy_div.sv @@
// Pipelined restoring divider: one quotient bit per stage.
module chfxy_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 16,
    parameter int TAG_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_vld,
    input  logic [NUM_W-1:0] in_num,
    input  logic [DEN_W-1:0] in_den,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_vld,
    output logic [NUM_W-1:0] out_quo,
    output logic [TAG_W-1:0] out_tag
);
    logic             vld_reg [NUM_W+1];
    logic [NUM_W-1:0] num_reg [NUM_W+1];
    logic [DEN_W:0]   rem_reg [NUM_W+1];
    logic [DEN_W-1:0] den_reg [NUM_W+1];
    logic [TAG_W-1:0] tag_reg [NUM_W+1];

    always_comb
    begin
        vld_reg[0] = in_vld;
        num_reg[0] = in_num;
        rem_reg[0] = '0;
        den_reg[0] = in_den;
        tag_reg[0] = in_tag;
    end

    for (genvar s = 0; s < NUM_W; s++)
    begin : g_stage
        logic [DEN_W+1:0] sh;
        logic [DEN_W+1:0] df;
        logic             q;
        always_comb
        begin
            sh = {rem_reg[s], num_reg[s][NUM_W-1]};
            df = sh - {2'b00, den_reg[s]};
            q  = ~df[DEN_W+1];
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s+1] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[s+1] <= vld_reg[s];
            end
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[s+1] <= q ? df[DEN_W:0] : sh[DEN_W:0];
                num_reg[s+1] <= {num_reg[s][NUM_W-2:0], q};
                den_reg[s+1] <= den_reg[s];
                tag_reg[s+1] <= tag_reg[s];
            end
        end
    end

    assign out_vld = vld_reg[NUM_W];
    assign out_quo = num_reg[NUM_W];
    assign out_tag = tag_reg[NUM_W];
endmodule

@@ verif/compass_heading_from_xy_test.sv @@
// Testbench for compass_heading_from_xy: fixed-point heading prediction, random idling, scoreboard.
module compass_heading_from_xy_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam int LATENCY = FRAC + 26;
    localparam int STALL_LIMIT = 4000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    chfxy_pkg::in_req_t  in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    chfxy_pkg::out_req_t out_data;
    logic       cfg_we = 1'b0;
    logic       cfg_index = chfxy_pkg::REG_X_OFFSET;
    logic [15:0] cfg_data = '0;

    logic signed [15:0] x_off = '0;
    logic signed [15:0] y_off = '0;
    chfxy_pkg::out_req_t heading_q[$];
    int         errors = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         quiet_cycles = 0;

    compass_heading_from_xy #(.FRACTION_BITS(FRAC)) u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint unsigned fx_const(logic [35:0] c32);
        return ((longint'(c32)) + (64'd1 << (31 - FRAC))) >> (32 - FRAC);
    endfunction

    function automatic longint unsigned mul_rnd(longint unsigned a, longint unsigned b);
        return (a * b + (64'd1 << (FRAC - 1))) >> FRAC;
    endfunction

    function automatic longint unsigned arctan_ratio(longint unsigned z);
        longint unsigned z2;
        longint unsigned t;
        z2 = mul_rnd(z, z);
        t = fx_const(chfxy_pkg::C32_A9);
        t = fx_const(chfxy_pkg::C32_A7) - mul_rnd(z2, t);
        t = fx_const(chfxy_pkg::C32_A5) - mul_rnd(z2, t);
        t = fx_const(chfxy_pkg::C32_A3) - mul_rnd(z2, t);
        t = fx_const(chfxy_pkg::C32_A1) - mul_rnd(z2, t);
        return mul_rnd(z, t);
    endfunction

    function automatic chfxy_pkg::out_req_t heading_of(logic signed [15:0] fx,
                                                       logic signed [15:0] fy);
        longint cx;
        longint cy;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned z;
        longint theta;
        longint pi_fx;
        longint unsigned centi;
        chfxy_pkg::out_req_t r;
        cx = longint'(fx) - longint'(x_off);
        cy = longint'(fy) - longint'(y_off);
        pi_fx = longint'(fx_const(chfxy_pkg::C32_PI));
        r = '0;
        if (cx == 0 && cy == 0)
        begin
            r.zero_vector = 1'b1;
            return r;
        end
        ax = cx < 0 ? -cx : cx;
        ay = cy < 0 ? -cy : cy;
        if (ay <= ax)
        begin
            z = (ay << FRAC) / ax;
            theta = longint'(arctan_ratio(z));
        end
        else
        begin
            z = (ax << FRAC) / ay;
            theta = longint'(fx_const(chfxy_pkg::C32_HALF_PI)) - longint'(arctan_ratio(z));
        end
        if (cx < 0) theta = pi_fx - theta;
        if (cy < 0) theta = -theta;
        if (theta < 0) theta += 2 * pi_fx;
        centi = (longint'(theta) * chfxy_pkg::CENTI_FULL_TURN + pi_fx) / (2 * pi_fx);
        if (centi >= chfxy_pkg::CENTI_FULL_TURN) centi -= chfxy_pkg::CENTI_FULL_TURN;
        r.heading_centideg = centi[15:0];
        return r;
    endfunction

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
            if (out_valid && !out_stall)
            begin
                if (heading_q.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $time, out_data);
                    errors++;
                end
                else if (out_data !== heading_q[0])
                begin
                    $display("%0t: mismatch expected %p actual %p", $time, heading_q[0], out_data);
                    errors++;
                    void'(heading_q.pop_front());
                end
                else
                    void'(heading_q.pop_front());
            end
        end
    end

    task automatic send_sample(logic signed [15:0] fx, logic signed [15:0] fy);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{field_x: fx, field_y: fy};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        heading_q.push_back(heading_of(fx, fy));
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (heading_q.size() != 0) @(posedge clk);
    endtask

    task automatic set_offsets(logic signed [15:0] xo, logic signed [15:0] yo);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= chfxy_pkg::REG_X_OFFSET;
        cfg_data <= xo;
        @(posedge clk);
        cfg_index <= chfxy_pkg::REG_Y_OFFSET;
        cfg_data <= yo;
        @(posedge clk);
        cfg_we <= 1'b0;
        x_off = xo;
        y_off = yo;
    endtask

    task automatic test_directed;
        set_offsets(16'sd0, 16'sd0);
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sd100, 16'sd0);
        send_sample(16'sd0, 16'sd100);
        send_sample(-16'sd100, 16'sd0);
        send_sample(16'sd0, -16'sd100);
        send_sample(16'sd500, 16'sd500);
        send_sample(-16'sd500, 16'sd500);
        send_sample(-16'sd500, -16'sd500);
        send_sample(16'sd500, -16'sd500);
        send_sample(16'sd32767, -16'sd1);
        send_sample(16'sd32767, 16'sd1);
        send_sample(-16'sd32768, -16'sd1);
        send_sample(-16'sd32768, 16'sd32767);
        send_sample(16'sd32767, -16'sd32768);
        send_sample(16'sd1, -16'sd32768);
        set_offsets(-16'sd32768, 16'sd32767);
        send_sample(16'sd32767, -16'sd32768);
        send_sample(-16'sd32768, 16'sd32767);
        send_sample(16'sd32767, 16'sd32766);
        set_offsets(16'sd32767, -16'sd32768);
        send_sample(-16'sd32768, 16'sd32767);
        send_sample(16'sd32767, -16'sd32768);
        send_sample(16'sd32766, -16'sd32768);
    endtask

    task automatic test_random(int count);
        logic signed [15:0] fx;
        logic signed [15:0] fy;
        int sel;
        for (int i = 0; i < count; i++)
        begin
            sel = int'($urandom_range(9));
            fx = 16'($urandom);
            fy = 16'($urandom);
            if (sel < 2)
            begin
                fx = x_off + $signed(16'($urandom_range(6))) - 16'sd3;
                fy = y_off + $signed(16'($urandom_range(6))) - 16'sd3;
            end
            else if (sel == 2)
                fy = 16'(y_off + ((fx - x_off) * ($urandom_range(1) ? 1 : -1)));
            else if (sel == 3)
                fy = y_off - $signed(16'($urandom_range(2)));
            send_sample(fx, fy);
        end
    endtask

    task automatic test_phase(int idle_in, int stall_out, logic signed [15:0] xo,
                              logic signed [15:0] yo, int count);
        set_offsets(xo, yo);
        send_idle_pct = idle_in;
        recv_stall_pct = stall_out;
        test_random(count);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_phase(12, 50, 16'sd0, 16'sd0, 230);
        test_phase(12, 50, -16'sd32768, 16'sd32767, 230);
        test_phase(50, 12, 16'sd32767, -16'sd32768, 230);
        test_phase(50, 12, 16'($urandom), 16'($urandom), 230);
        test_phase(0, 0, 16'($urandom), 16'($urandom), 230);
        test_phase(0, 0, 16'sd0, 16'sd0, 230);
        drain();
        repeat (LATENCY + 20) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
